FILE: hdl/obb_pair_intersection_test_core_macros.svh
// Assertion helpers for the box intersection core.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef OBB_PAIR_INTERSECTION_TEST_CORE_MACROS_SVH
`define OBB_PAIR_INTERSECTION_TEST_CORE_MACROS_SVH

// same-cycle implication
`define OBBPIT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OBBPIT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/obbpit_pkg.sv
// ---------------------------------------------------------------------------
// obbpit_pkg
// Shared constants and control types of the oriented box intersection core.
// ---------------------------------------------------------------------------
package obbpit_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int TRIG_BITS_DEF  = 16;

	// box extents are fixed at 20 bits
	localparam int DIM_BITS = 20;

	// sine polynomial, Q.30
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [30:0] POLY_A  = 31'd1686629713;
	localparam logic [30:0] POLY_B  = 31'd688904866;
	localparam logic [30:0] POLY_C  = 31'd76016977;

	// register stages from accept to result strobe
	localparam int PIPE_LAT = 13;

	typedef struct packed {
		logic vld;
		logic rej;
	} ctl_t;

endpackage

FILE: hdl/obbpit_sincos.sv
// ---------------------------------------------------------------------------
// obbpit_sincos
// Five-stage fixed-point sine: quadrant fold, odd polynomial in Q.30,
// rounding to TRIG_BITS and sign by quadrant.
// ---------------------------------------------------------------------------
module obbpit_sincos #(
	parameter int ANGLE_BITS = obbpit_pkg::ANGLE_BITS_DEF,
	parameter int TRIG_BITS  = obbpit_pkg::TRIG_BITS_DEF
) (
	input  logic                        clk,
	input  logic [ANGLE_BITS-1:0]       ang,
	output logic signed [TRIG_BITS+1:0] val
);
	localparam int FB = ANGLE_BITS - 2;

	logic [1:0]  quad;
	logic [30:0] z_in;
	logic [61:0] p_zz, p_cz, p_tz, p_zt;
	logic [31:0] rsum;
	logic [TRIG_BITS+1:0] mag;

	logic [30:0] z_s2, z2_s2, z_s3, z2_s3, t1_s3, z_s4, t2_s4, r_s5;
	logic        neg_s2, neg_s3, neg_s4, neg_s5;

	always_comb begin
		quad = ang[ANGLE_BITS-1 -: 2];
		z_in = 31'(ang[FB-1:0]) << (30 - FB);
		if (quad[0]) begin
			z_in = obbpit_pkg::Q30_ONE - z_in;
		end
		p_zz = 62'(z_in) * 62'(z_in);
		p_cz = 62'(obbpit_pkg::POLY_C) * 62'(z2_s2);
		p_tz = 62'(t1_s3) * 62'(z2_s3);
		p_zt = 62'(z_s4) * 62'(t2_s4);
		rsum = 32'(r_s5) + (32'd1 << (29 - TRIG_BITS));
		mag  = rsum[30-TRIG_BITS +: TRIG_BITS+2];
	end

	always_ff @(posedge clk) begin
		z_s2   <= z_in;
		z2_s2  <= p_zz[60:30];
		neg_s2 <= quad[1];

		z_s3   <= z_s2;
		z2_s3  <= z2_s2;
		t1_s3  <= obbpit_pkg::POLY_B - p_cz[60:30];
		neg_s3 <= neg_s2;

		z_s4   <= z_s3;
		t2_s4  <= obbpit_pkg::POLY_A - p_tz[60:30];
		neg_s4 <= neg_s3;

		r_s5   <= p_zt[60:30];
		neg_s5 <= neg_s4;

		val    <= neg_s5 ? -$signed(mag) : $signed(mag);
	end

endmodule

FILE: hdl/obbpit_corners.sv
// ---------------------------------------------------------------------------
// obbpit_corners
// Two stages: extent times sin/cos, then the four rounded corners of each
// box in doubled coordinates relative to the first center.
// ---------------------------------------------------------------------------
module obbpit_corners #(
	parameter int COORD_BITS = obbpit_pkg::COORD_BITS_DEF,
	parameter int TRIG_BITS  = obbpit_pkg::TRIG_BITS_DEF,
	parameter int CRN_W      = ((COORD_BITS + 1 > 22) ? COORD_BITS + 1 : 22) + 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  obbpit_pkg::ctl_t                  ctl_i,
	input  logic signed [TRIG_BITS+1:0]       sn_i [2],
	input  logic signed [TRIG_BITS+1:0]       cs_i [2],
	input  logic [obbpit_pkg::DIM_BITS-1:0]   w_i  [2],
	input  logic [obbpit_pkg::DIM_BITS-1:0]   h_i  [2],
	input  logic signed [COORD_BITS:0]        dx_i,
	input  logic signed [COORD_BITS:0]        dy_i,
	output obbpit_pkg::ctl_t                  ctl_o,
	output logic signed [TRIG_BITS+1:0]       sn_o [2],
	output logic signed [TRIG_BITS+1:0]       cs_o [2],
	output logic signed [CRN_W-1:0]           px_o [2][4],
	output logic signed [CRN_W-1:0]           py_o [2][4]
);
	localparam int SW  = TRIG_BITS + 2;
	localparam int PRW = obbpit_pkg::DIM_BITS + 1 + SW;
	localparam int OW  = PRW + 1;

	obbpit_pkg::ctl_t ctl_s7;
	logic signed [SW-1:0]     sn_s7 [2], cs_s7 [2];
	logic signed [PRW-1:0]    wc_s7 [2], ws_s7 [2], hc_s7 [2], hs_s7 [2];
	logic signed [COORD_BITS:0] dx_s7, dy_s7;

	logic signed [OW-1:0] ox [2][4], oy [2][4];
	logic signed [OW-1:0] half;
	logic signed [CRN_W-1:0] bx [2], by [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s7 <= '0;
			ctl_o  <= '0;
		end else begin
			ctl_s7 <= ctl_i;
			ctl_o  <= ctl_s7;
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < 2; b++) begin
			wc_s7[b] <= $signed({1'b0, w_i[b]}) * cs_i[b];
			ws_s7[b] <= $signed({1'b0, w_i[b]}) * sn_i[b];
			hc_s7[b] <= $signed({1'b0, h_i[b]}) * cs_i[b];
			hs_s7[b] <= $signed({1'b0, h_i[b]}) * sn_i[b];
			sn_s7[b] <= sn_i[b];
			cs_s7[b] <= cs_i[b];
		end
		dx_s7 <= dx_i;
		dy_s7 <= dy_i;
	end

	always_comb begin
		half  = OW'(1) <<< (TRIG_BITS - 1);
		bx[0] = '0;
		by[0] = '0;
		bx[1] = CRN_W'(dx_s7) <<< 1;
		by[1] = CRN_W'(dy_s7) <<< 1;
		for (int b = 0; b < 2; b++) begin
			ox[b][0] = -OW'(wc_s7[b]) + OW'(hs_s7[b]) + half;
			ox[b][1] =  OW'(wc_s7[b]) + OW'(hs_s7[b]) + half;
			ox[b][2] =  OW'(wc_s7[b]) - OW'(hs_s7[b]) + half;
			ox[b][3] = -OW'(wc_s7[b]) - OW'(hs_s7[b]) + half;
			oy[b][0] = -OW'(ws_s7[b]) - OW'(hc_s7[b]) + half;
			oy[b][1] =  OW'(ws_s7[b]) - OW'(hc_s7[b]) + half;
			oy[b][2] =  OW'(ws_s7[b]) + OW'(hc_s7[b]) + half;
			oy[b][3] = -OW'(ws_s7[b]) + OW'(hc_s7[b]) + half;
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < 2; b++) begin
			for (int k = 0; k < 4; k++) begin
				px_o[b][k] <= bx[b] + CRN_W'(ox[b][k] >>> TRIG_BITS);
				py_o[b][k] <= by[b] + CRN_W'(oy[b][k] >>> TRIG_BITS);
			end
			sn_o[b] <= sn_s7[b];
			cs_o[b] <= cs_s7[b];
		end
	end

endmodule

FILE: hdl/obbpit_sat.sv
// ---------------------------------------------------------------------------
// obbpit_sat
// Separating axis stage: projects both corner sets on the four box axes,
// reduces to intervals over two compare levels and checks strict overlap.
// ---------------------------------------------------------------------------
`include "obb_pair_intersection_test_core_macros.svh"

module obbpit_sat #(
	parameter int COORD_BITS = obbpit_pkg::COORD_BITS_DEF,
	parameter int TRIG_BITS  = obbpit_pkg::TRIG_BITS_DEF,
	parameter int CRN_W      = ((COORD_BITS + 1 > 22) ? COORD_BITS + 1 : 22) + 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  obbpit_pkg::ctl_t            ctl_i,
	input  logic signed [TRIG_BITS+1:0] sn_i [2],
	input  logic signed [TRIG_BITS+1:0] cs_i [2],
	input  logic signed [CRN_W-1:0]     px_i [2][4],
	input  logic signed [CRN_W-1:0]     py_i [2][4],
	output logic                        done,
	output logic                        overlap
);
	localparam int SW  = TRIG_BITS + 2;
	localparam int MW  = CRN_W + SW;
	localparam int PW  = MW + 1;

	obbpit_pkg::ctl_t ctl_s9, ctl_s10, ctl_s11, ctl_s12;
	logic signed [SW-1:0] ax [4], ay [4];
	logic signed [MW-1:0] mx_s9 [2][4][4], my_s9 [2][4][4];
	logic signed [PW-1:0] pr_s10 [2][4][4];
	logic signed [PW-1:0] lo01_s11 [2][4], hi01_s11 [2][4];
	logic signed [PW-1:0] lo23_s11 [2][4], hi23_s11 [2][4];
	logic signed [PW-1:0] lo_s12 [2][4], hi_s12 [2][4];
	logic [3:0] sep;
	logic       vld_s13, ovl_s13;

	// axes: (c1,s1), (-s1,c1), (c2,s2), (-s2,c2)
	always_comb begin
		for (int b = 0; b < 2; b++) begin
			ax[2*b]   = cs_i[b];
			ay[2*b]   = sn_i[b];
			ax[2*b+1] = -sn_i[b];
			ay[2*b+1] = cs_i[b];
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < 2; b++) begin
			for (int a = 0; a < 4; a++) begin
				for (int k = 0; k < 4; k++) begin
					mx_s9[b][a][k]  <= px_i[b][k] * ax[a];
					my_s9[b][a][k]  <= py_i[b][k] * ay[a];
					pr_s10[b][a][k] <= PW'(mx_s9[b][a][k]) + PW'(my_s9[b][a][k]);
				end
				lo01_s11[b][a] <= (pr_s10[b][a][1] < pr_s10[b][a][0]) ?
					pr_s10[b][a][1] : pr_s10[b][a][0];
				hi01_s11[b][a] <= (pr_s10[b][a][1] > pr_s10[b][a][0]) ?
					pr_s10[b][a][1] : pr_s10[b][a][0];
				lo23_s11[b][a] <= (pr_s10[b][a][3] < pr_s10[b][a][2]) ?
					pr_s10[b][a][3] : pr_s10[b][a][2];
				hi23_s11[b][a] <= (pr_s10[b][a][3] > pr_s10[b][a][2]) ?
					pr_s10[b][a][3] : pr_s10[b][a][2];
				lo_s12[b][a] <= (lo23_s11[b][a] < lo01_s11[b][a]) ?
					lo23_s11[b][a] : lo01_s11[b][a];
				hi_s12[b][a] <= (hi23_s11[b][a] > hi01_s11[b][a]) ?
					hi23_s11[b][a] : hi01_s11[b][a];
			end
		end
	end

	// touching intervals count as separated
	always_comb begin
		for (int a = 0; a < 4; a++) begin
			sep[a] = !((lo_s12[0][a] < hi_s12[1][a]) && (hi_s12[0][a] > lo_s12[1][a]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s9  <= '0;
			ctl_s10 <= '0;
			ctl_s11 <= '0;
			ctl_s12 <= '0;
			vld_s13 <= 1'b0;
			ovl_s13 <= 1'b0;
		end else begin
			ctl_s9  <= ctl_i;
			ctl_s10 <= ctl_s9;
			ctl_s11 <= ctl_s10;
			ctl_s12 <= ctl_s11;
			vld_s13 <= ctl_s12.vld;
			ovl_s13 <= ctl_s12.vld && !ctl_s12.rej && (sep == 4'b0000);
		end
	end

	assign done    = vld_s13;
	assign overlap = ovl_s13;

	`OBBPIT_ASSERT_NEXT(a_reject_no_overlap, ctl_s12.vld && ctl_s12.rej, !overlap, "rejected pair reported overlap")
	`OBBPIT_ASSERT_IMPL(a_overlap_with_done, overlap, done, "overlap high without result strobe")

endmodule

FILE: hdl/obb_pair_intersection_test_core.sv
// ---------------------------------------------------------------------------
// obb_pair_intersection_test_core
// Overlap test of two 2D oriented boxes by separating axes, with an early
// reject on center distance against both squared diagonals.
//
//   channel | handshake          | words
//   --------+--------------------+---------------------------------------
//   input   | start / busy       | first_* and second_* box fields
//   result  | done (one cycle)   | overlap
//
// One pair is taken every cycle; busy stays low.
// The path from accept to done runs through the five-stage sine polynomial
// and the eight-way projection multiply and min/max tree.
// arst_n clears all valid bits; data registers are not reset.
// The receiver cannot hold off results, so the pipeline never stalls.
// ---------------------------------------------------------------------------
`include "obb_pair_intersection_test_core_macros.svh"

module obb_pair_intersection_test_core #(
	parameter int COORD_BITS = obbpit_pkg::COORD_BITS_DEF,
	parameter int ANGLE_BITS = obbpit_pkg::ANGLE_BITS_DEF,
	parameter int TRIG_BITS  = obbpit_pkg::TRIG_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_BITS-1:0]        first_center_x,
	input  logic signed [COORD_BITS-1:0]        first_center_y,
	input  logic [obbpit_pkg::DIM_BITS-1:0]     first_width,
	input  logic [obbpit_pkg::DIM_BITS-1:0]     first_height,
	input  logic [ANGLE_BITS-1:0]               first_angle,
	input  logic signed [COORD_BITS-1:0]        second_center_x,
	input  logic signed [COORD_BITS-1:0]        second_center_y,
	input  logic [obbpit_pkg::DIM_BITS-1:0]     second_width,
	input  logic [obbpit_pkg::DIM_BITS-1:0]     second_height,
	input  logic [ANGLE_BITS-1:0]               second_angle,
	output logic                                done,
	output logic                                overlap
);
	localparam int DB    = obbpit_pkg::DIM_BITS;
	localparam int CRN_W = ((COORD_BITS + 1 > 22) ? COORD_BITS + 1 : 22) + 2;
	localparam int SQC   = 2 * COORD_BITS + 1;
	localparam int SQD   = 2 * DB;
	localparam int EW    = ((SQC + 1 > SQD + 1) ? SQC + 1 : SQD + 1);
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

	typedef struct packed {
		logic [DB-1:0]         w1;
		logic [DB-1:0]         h1;
		logic [DB-1:0]         w2;
		logic [DB-1:0]         h2;
		logic [COORD_BITS:0]   dx;
		logic [COORD_BITS:0]   dy;
	} geom_t;

	logic vld_s1, vld_s2, vld_s3;
	obbpit_pkg::ctl_t ctl_s4, ctl_s5, ctl_s6, ctl_s8;
	geom_t geom_s1, geom_s2, geom_s3, geom_s4, geom_s5, geom_s6;
	logic [ANGLE_BITS-1:0] ang_s1 [4];

	logic signed [2*COORD_BITS+1:0] dxx, dyy;
	logic [SQC-1:0] dx2_s2, dy2_s2;
	logic [SQD-1:0] w1q_s2, h1q_s2, w2q_s2, h2q_s2;
	logic [EW-1:0]  dist_s3, r1_s3, r2_s3;

	logic signed [TRIG_BITS+1:0] trig_s6 [4];
	logic signed [TRIG_BITS+1:0] sn6 [2], cs6 [2], sn8 [2], cs8 [2];
	logic [DB-1:0] w6 [2], h6 [2];
	logic signed [CRN_W-1:0] px8 [2][4], py8 [2][4];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else begin
			vld_s1     <= start && !busy;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			ctl_s4.vld <= vld_s3;
			// reject when farther than both diagonals
			ctl_s4.rej <= (dist_s3 > r1_s3) && (dist_s3 > r2_s3);
			ctl_s5     <= ctl_s4;
			ctl_s6     <= ctl_s5;
		end
	end

	always_comb begin
		dxx = $signed(geom_s1.dx) * $signed(geom_s1.dx);
		dyy = $signed(geom_s1.dy) * $signed(geom_s1.dy);
	end

	always_ff @(posedge clk) begin
		geom_s1.w1 <= first_width;
		geom_s1.h1 <= first_height;
		geom_s1.w2 <= second_width;
		geom_s1.h2 <= second_height;
		geom_s1.dx <= (COORD_BITS+1)'(second_center_x) - (COORD_BITS+1)'(first_center_x);
		geom_s1.dy <= (COORD_BITS+1)'(second_center_y) - (COORD_BITS+1)'(first_center_y);
		ang_s1[0]  <= first_angle;
		ang_s1[1]  <= first_angle + QUARTER;
		ang_s1[2]  <= second_angle;
		ang_s1[3]  <= second_angle + QUARTER;

		dx2_s2 <= dxx[SQC-1:0];
		dy2_s2 <= dyy[SQC-1:0];
		w1q_s2 <= geom_s1.w1 * geom_s1.w1;
		h1q_s2 <= geom_s1.h1 * geom_s1.h1;
		w2q_s2 <= geom_s1.w2 * geom_s1.w2;
		h2q_s2 <= geom_s1.h2 * geom_s1.h2;

		dist_s3 <= EW'(dx2_s2) + EW'(dy2_s2);
		r1_s3   <= EW'(w1q_s2) + EW'(h1q_s2);
		r2_s3   <= EW'(w2q_s2) + EW'(h2q_s2);

		geom_s2 <= geom_s1;
		geom_s3 <= geom_s2;
		geom_s4 <= geom_s3;
		geom_s5 <= geom_s4;
		geom_s6 <= geom_s5;
	end

	for (genvar i = 0; i < 4; i++) begin : g_trig
		obbpit_sincos #(
			.ANGLE_BITS(ANGLE_BITS),
			.TRIG_BITS (TRIG_BITS)
		) u_sincos (
			.clk(clk),
			.ang(ang_s1[i]),
			.val(trig_s6[i])
		);
	end

	always_comb begin
		sn6[0] = trig_s6[0];
		cs6[0] = trig_s6[1];
		sn6[1] = trig_s6[2];
		cs6[1] = trig_s6[3];
		w6[0]  = geom_s6.w1;
		h6[0]  = geom_s6.h1;
		w6[1]  = geom_s6.w2;
		h6[1]  = geom_s6.h2;
	end

	obbpit_corners #(
		.COORD_BITS(COORD_BITS),
		.TRIG_BITS (TRIG_BITS),
		.CRN_W     (CRN_W)
	) u_corners (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl_i (ctl_s6),
		.sn_i  (sn6),
		.cs_i  (cs6),
		.w_i   (w6),
		.h_i   (h6),
		.dx_i  ($signed(geom_s6.dx)),
		.dy_i  ($signed(geom_s6.dy)),
		.ctl_o (ctl_s8),
		.sn_o  (sn8),
		.cs_o  (cs8),
		.px_o  (px8),
		.py_o  (py8)
	);

	obbpit_sat #(
		.COORD_BITS(COORD_BITS),
		.TRIG_BITS (TRIG_BITS),
		.CRN_W     (CRN_W)
	) u_sat (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_s8),
		.sn_i   (sn8),
		.cs_i   (cs8),
		.px_i   (px8),
		.py_i   (py8),
		.done   (done),
		.overlap(overlap)
	);

	`OBBPIT_ASSERT_IMPL(a_word_completes, start, ##13 done, "accepted word produced no result")
	`OBBPIT_ASSERT_IMPL(a_no_spurious_done, !start, ##13 !done, "result strobe without accepted word")

endmodule
